>>> rtl/core/lbc_pkg.sv
// Shared types and constants for the LRU block cache with pending marks.
package lbc_pkg;

  localparam int unsigned FILE_PORT_W = 16;
  localparam int unsigned BLK_W       = 23;
  localparam int unsigned OFF_W       = 32;
  localparam int unsigned SIZE_W      = 21;
  localparam int unsigned OCC_W       = 7;
  localparam int unsigned CB_W        = 7;
  localparam int unsigned SH_W        = 5;
  localparam int unsigned INBLK_W     = 20;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [SH_W-1:0] SH_MIN   = 5'd9;
  localparam logic [SH_W-1:0] SH_MAX   = 5'd20;
  localparam logic [SH_W-1:0] SH_RESET = 5'd12;
  localparam logic [CB_W-1:0] CB_RESET = 7'd64;

  localparam logic [1:0] REQ_READ     = 2'd0;
  localparam int unsigned REQ_RESP_BIT = 1;

  // register select is address bit 2
  localparam logic REG_CACHE_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_SHIFT  = 1'b1;

  typedef enum logic [3:0] {
    OC_READ_HIT   = 4'd0,
    OC_READ_MISS  = 4'd1,
    OC_WRITE_HIT  = 4'd2,
    OC_WRITE_COAL = 4'd3,
    OC_WRITE_MISS = 4'd4,
    OC_BYPASS     = 4'd5,
    OC_RESP_CLEAR = 4'd6,
    OC_RESP_MISS  = 4'd7,
    OC_SIZE_ERR   = 4'd8
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_INSERT
  } op_e;

  typedef struct packed {
    logic hit;
    logic hit_pend;
    logic any_clean;
  } scan_flags_t;

endpackage

>>> rtl/core/lbc_ram.sv
// Entry memory: one write port, one read port, registered read data.
module lbc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lbc_scan.sv
// Sweep accumulator: finds the hit, the LRU tail, the first free entry and whether any entry is clean.
module lbc_scan
  import lbc_pkg::*;
#(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned FILE_W   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        vld_i,
  input  logic [$clog2(CAPACITY)-1:0] idx_i,
  input  logic [2+FILE_W+BLK_W+$clog2(CAPACITY)-1:0] word_i,
  input  logic [FILE_W-1:0]           fid_i,
  input  logic [BLK_W-1:0]            blk_i,
  output scan_flags_t                 flags_o,
  output logic [$clog2(CAPACITY)-1:0] hit_idx_o,
  output logic [$clog2(CAPACITY)-1:0] hit_age_o,
  output logic [$clog2(CAPACITY)-1:0] lru_idx_o,
  output logic [FILE_W-1:0]           lru_file_o,
  output logic [BLK_W-1:0]            lru_block_o,
  output logic [$clog2(CAPACITY)-1:0] free_idx_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned AGE_W  = IDX_W;
  localparam int unsigned WORD_W = 2 + FILE_W + BLK_W + AGE_W;

  logic              w_valid;
  logic              w_pend;
  logic [FILE_W-1:0] w_file;
  logic [BLK_W-1:0]  w_blk;
  logic [AGE_W-1:0]  w_age;
  logic              match;
  logic              take_lru;
  logic              take_free;

  scan_flags_t       flags_q;
  logic              lru_found_q;
  logic              free_found_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [AGE_W-1:0]  hit_age_q;
  logic [IDX_W-1:0]  lru_idx_q;
  logic [AGE_W-1:0]  lru_age_q;
  logic [FILE_W-1:0] lru_file_q;
  logic [BLK_W-1:0]  lru_block_q;
  logic [IDX_W-1:0]  free_idx_q;

  assign w_valid = word_i[WORD_W-1];
  assign w_pend  = word_i[WORD_W-2];
  assign w_file  = word_i[AGE_W+BLK_W +: FILE_W];
  assign w_blk   = word_i[AGE_W +: BLK_W];
  assign w_age   = word_i[AGE_W-1:0];

  assign match     = w_valid && (w_file == fid_i) && (w_blk == blk_i) && !flags_q.hit;
  assign take_lru  = w_valid && (!lru_found_q || (w_age > lru_age_q));
  assign take_free = !w_valid && !free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      lru_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (clr_i) begin
      flags_q      <= '0;
      lru_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (vld_i) begin
      if (match) begin
        flags_q.hit      <= 1'b1;
        flags_q.hit_pend <= w_pend;
      end
      if (w_valid && !w_pend) begin
        flags_q.any_clean <= 1'b1;
      end
      if (take_lru) begin
        lru_found_q <= 1'b1;
      end
      if (take_free) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !clr_i) begin
      if (match) begin
        hit_idx_q <= idx_i;
        hit_age_q <= w_age;
      end
      if (take_lru) begin
        lru_idx_q   <= idx_i;
        lru_age_q   <= w_age;
        lru_file_q  <= w_file;
        lru_block_q <= w_blk;
      end
      if (take_free) begin
        free_idx_q <= idx_i;
      end
    end
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_age_o   = hit_age_q;
  assign lru_idx_o   = lru_idx_q;
  assign lru_file_o  = lru_file_q;
  assign lru_block_o = lru_block_q;
  assign free_idx_o  = free_idx_q;

endmodule

>>> rtl/core/lru_block_cache_with_pending_core.sv
// Fully associative LRU cache of file blocks with pending marks.
//
// Usage: drive req_type_i, file_id_i, offset_i and size_i and raise start; the
// item is taken at the edge where start is high and busy is low. One result per
// item appears on the result ports for one cycle, marked by done_o; the
// receiver cannot stall, so it must take it in that cycle.
// All entries live in one synchronous memory. Each item first sweeps every
// entry to find the hit, the LRU tail, a free entry and whether every entry
// is pending, then decides in the DECIDE state; done_o is registered from
// that state. If the item refreshes, marks or inserts an entry, a second
// read-modify-write sweep follows before busy falls. The sweeps run through
// the one memory port, so the block takes no new item until it is through
// with the last one.
// Reset: registers go to cache_blocks=64, block_shift=12, and a clearing pass
// zeroes the memory while busy is high. Configuration writes on the APB port
// are taken at any time but are meant for idle periods.
module lru_block_cache_with_pending_core
  import lbc_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned FILE_ID_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item channel
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type_i,
  input  logic [FILE_PORT_W-1:0] file_id_i,
  input  logic [OFF_W-1:0]       offset_i,
  input  logic [SIZE_W-1:0]      size_i,
  // results
  output logic                   done_o,
  output logic [3:0]             outcome_o,
  output logic                   evicted_o,
  output logic [FILE_PORT_W-1:0] evicted_file_o,
  output logic [BLK_W-1:0]       evicted_block_o,
  output logic                   flush_now_o,
  output logic [OCC_W-1:0]       occupancy_o,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned AGE_W  = IDX_W;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned FILE_W = (FILE_ID_BITS < FILE_PORT_W) ? FILE_ID_BITS : FILE_PORT_W;
  localparam int unsigned WORD_W = 2 + FILE_W + BLK_W + AGE_W;
  localparam int unsigned CMP_W  = (CNT_W > CB_W) ? CNT_W : CB_W;

  // configuration
  logic [CB_W-1:0]  cache_blocks_q;
  logic [SH_W-1:0]  block_shift_q;
  logic [SH_W-1:0]  sh_eff;
  logic [CMP_W-1:0] cb_ext;
  logic [CMP_W-1:0] blocks_eff;
  logic             cfg_we;

  // control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [CNT_W-1:0] count_q;
  logic             accept;
  logic             rd_en;
  logic             sweep_end;

  // captured item
  logic [1:0]         type_q;
  logic [FILE_W-1:0]  fid_q;
  logic [BLK_W-1:0]   blk_q;
  logic [INBLK_W-1:0] inblk_q;
  logic [SIZE_W-1:0]  size_q;

  // pending update
  op_e              op_q, op_d;
  logic [IDX_W-1:0] tgt_idx_q, tgt_idx_d;
  logic [AGE_W-1:0] tgt_age_q, tgt_age_d;
  logic             new_pend_q, new_pend_d;

  // result registers
  logic                   done_q;
  outcome_e               outcome_q, outcome_d;
  logic                   evicted_q, evicted_d;
  logic [FILE_PORT_W-1:0] ev_file_q, ev_file_d;
  logic [BLK_W-1:0]       ev_blk_q, ev_blk_d;
  logic                   flush_q, flush_d;
  logic [CNT_W-1:0]       count_d;

  // memory
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // scan results
  scan_flags_t       flags;
  logic [IDX_W-1:0]  hit_idx;
  logic [AGE_W-1:0]  hit_age;
  logic [IDX_W-1:0]  lru_idx;
  logic [FILE_W-1:0] lru_file;
  logic [BLK_W-1:0]  lru_block;
  logic [IDX_W-1:0]  free_idx;

  // decision
  logic             full;
  logic             allpend;
  logic             size_err;
  logic [CNT_W-1:0] count_ins;

  // read-modify-write
  logic              m_valid;
  logic [AGE_W-1:0]  m_age;
  logic [WORD_W-1:0] m_word;

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_blocks_q <= CB_RESET;
      block_shift_q  <= SH_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_CACHE_BLOCKS: cache_blocks_q <= pwdata[CB_W-1:0];
        REG_BLOCK_SHIFT:  block_shift_q  <= pwdata[SH_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CACHE_BLOCKS: prdata = APB_DATA_W'(cache_blocks_q);
      REG_BLOCK_SHIFT:  prdata = APB_DATA_W'(block_shift_q);
      default:          prdata = '0;
    endcase
  end

  assign sh_eff = (block_shift_q < SH_MIN) ? SH_MIN :
                  (block_shift_q > SH_MAX) ? SH_MAX : block_shift_q;

  assign cb_ext     = CMP_W'(cache_blocks_q);
  assign blocks_eff = (cb_ext == '0) ? CMP_W'(1) :
                      (cb_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : cb_ext;

  //--------------------------------------------------------------------------
  // item capture
  //--------------------------------------------------------------------------
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q  <= req_type_i;
      fid_q   <= file_id_i[FILE_W-1:0];
      blk_q   <= BLK_W'(offset_i >> sh_eff);
      inblk_q <= INBLK_W'(offset_i & ((OFF_W'(1) << sh_eff) - OFF_W'(1)));
      size_q  <= size_i;
    end
  end

  //--------------------------------------------------------------------------
  // memory and sweep
  //--------------------------------------------------------------------------
  assign sweep_end = (cnt_q == CNT_W'(CAPACITY));
  assign rd_en     = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && !sweep_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IDX_W-1:0];
  end

  lbc_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  lbc_scan #(
    .CAPACITY (CAPACITY),
    .FILE_W   (FILE_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (accept),
    .vld_i       (rd_vld_q && (state_q == ST_SCAN)),
    .idx_i       (rd_idx_q),
    .word_i      (mem_rdata),
    .fid_i       (fid_q),
    .blk_i       (blk_q),
    .flags_o     (flags),
    .hit_idx_o   (hit_idx),
    .hit_age_o   (hit_age),
    .lru_idx_o   (lru_idx),
    .lru_file_o  (lru_file),
    .lru_block_o (lru_block),
    .free_idx_o  (free_idx)
  );

  // modify step of the update sweep
  assign m_valid = mem_rdata[WORD_W-1];
  assign m_age   = mem_rdata[AGE_W-1:0];

  always_comb begin
    m_word = mem_rdata;
    if (op_q == OP_INSERT) begin
      if (rd_idx_q == tgt_idx_q) begin
        m_word = {1'b1, 1'b1, fid_q, blk_q, AGE_W'(0)};
      end else if (m_valid) begin
        m_word[AGE_W-1:0] = m_age + AGE_W'(1);
      end
    end else begin
      if (rd_idx_q == tgt_idx_q) begin
        m_word[AGE_W-1:0] = '0;
        m_word[WORD_W-2]  = new_pend_q;
      end else if (m_valid && (m_age < tgt_age_q)) begin
        m_word[AGE_W-1:0] = m_age + AGE_W'(1);
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IDX_W-1:0];
        mem_wdata = '0;
      end
      ST_UPDATE: begin
        mem_we    = rd_vld_q;
        mem_waddr = rd_idx_q;
        mem_wdata = m_word;
      end
      default: begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_q;
        mem_wdata = m_word;
      end
    endcase
  end

  //--------------------------------------------------------------------------
  // decision
  //--------------------------------------------------------------------------
  assign full      = (CMP_W'(count_q) >= blocks_eff);
  assign allpend   = (count_q != '0) && !flags.any_clean;
  assign size_err  = (SUM_W'(inblk_q) + SUM_W'(size_q)) > (SUM_W'(1) << sh_eff);
  assign count_ins = full ? count_q : CNT_W'(count_q + CNT_W'(1));

  always_comb begin
    outcome_d  = OC_RESP_MISS;
    evicted_d  = 1'b0;
    ev_file_d  = '0;
    ev_blk_d   = '0;
    flush_d    = 1'b0;
    count_d    = count_q;
    op_d       = OP_NONE;
    tgt_idx_d  = hit_idx;
    tgt_age_d  = hit_age;
    new_pend_d = 1'b0;
    if (type_q[REQ_RESP_BIT]) begin
      if (flags.hit) begin
        outcome_d = OC_RESP_CLEAR;
        op_d      = OP_TOUCH;
      end
    end else if (!flags.hit && full && allpend) begin
      outcome_d = OC_BYPASS;
    end else if (flags.hit) begin
      if (type_q == REQ_READ) begin
        outcome_d = OC_READ_HIT;
        if (!flags.hit_pend) begin
          op_d = OP_TOUCH;
        end
      end else if (!flags.hit_pend) begin
        outcome_d  = OC_WRITE_HIT;
        op_d       = OP_TOUCH;
        new_pend_d = 1'b1;
        flush_d    = full;
      end else begin
        outcome_d = OC_WRITE_COAL;
      end
    end else if (size_err) begin
      outcome_d = OC_SIZE_ERR;
    end else begin
      op_d      = OP_INSERT;
      tgt_idx_d = full ? lru_idx : free_idx;
      count_d   = count_ins;
      if (full) begin
        evicted_d = 1'b1;
        ev_file_d = FILE_PORT_W'(lru_file);
        ev_blk_d  = lru_block;
      end
      if (type_q == REQ_READ) begin
        outcome_d = OC_READ_MISS;
      end else begin
        outcome_d = OC_WRITE_MISS;
        flush_d   = (CMP_W'(count_ins) >= blocks_eff);
      end
    end
  end

  //--------------------------------------------------------------------------
  // sequencer
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      count_q <= '0;
      op_q    <= OP_NONE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == ST_DECIDE);
      if (state_q == ST_DECIDE) begin
        count_q <= count_d;
        op_q    <= op_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      tgt_idx_q  <= tgt_idx_d;
      tgt_age_q  <= tgt_age_d;
      new_pend_q <= new_pend_d;
      outcome_q  <= outcome_d;
      evicted_q  <= evicted_d;
      ev_file_q  <= ev_file_d;
      ev_blk_q   <= ev_blk_d;
      flush_q    <= flush_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = CNT_W'(cnt_q + CNT_W'(1));
        if (cnt_q == CNT_W'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = CNT_W'(cnt_q + CNT_W'(1));
        if (sweep_end) begin
          state_d = ST_DECIDE;
          cnt_d   = '0;
        end
      end
      ST_DECIDE: begin
        cnt_d   = '0;
        state_d = (op_d == OP_NONE) ? ST_IDLE : ST_UPDATE;
      end
      ST_UPDATE: begin
        cnt_d = CNT_W'(cnt_q + CNT_W'(1));
        if (sweep_end) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  assign done_o          = done_q;
  assign outcome_o       = outcome_q;
  assign evicted_o       = evicted_q;
  assign evicted_file_o  = ev_file_q;
  assign evicted_block_o = ev_blk_q;
  assign flush_now_o     = flush_q;
  assign occupancy_o     = OCC_W'(count_q);

endmodule

>>> rtl/core/lbc_checker.sv
// Port-level checks for the block cache, bound to the top level.
module lbc_checker
  import lbc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [3:0]             outcome_o,
  input logic                   evicted_o,
  input logic [FILE_PORT_W-1:0] evicted_file_o,
  input logic [BLK_W-1:0]       evicted_block_o,
  input logic                   flush_now_o
);

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a preceding busy period");

  // eviction only on an inserting miss, and fields are zero otherwise
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |->
      (outcome_o == OC_READ_MISS || outcome_o == OC_WRITE_MISS))
    else $error("eviction reported on a non-inserting outcome");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_file_o == '0 && evicted_block_o == '0))
    else $error("evicted fields set without an eviction");

  // flush only for writes that queued a block
  a_flush_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flush_now_o) |->
      (outcome_o == OC_WRITE_HIT || outcome_o == OC_WRITE_MISS))
    else $error("flush_now on an outcome that queues no write");

endmodule

bind lru_block_cache_with_pending_core lbc_checker u_lbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .outcome_o       (outcome_o),
  .evicted_o       (evicted_o),
  .evicted_file_o  (evicted_file_o),
  .evicted_block_o (evicted_block_o),
  .flush_now_o     (flush_now_o)
);
